// ===== rtl/core/pidct_pkg.sv =====
`timescale 1ns / 1ps

package pidct_pkg;

    // data and configuration port widths
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;

    // datapath widths
    localparam int FRAC_W = 16;
    localparam int DIFF_W = DATA_W + 1;
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = PROD_W + MUL_W;
    localparam int PTM_W  = PROD_W - FRAC_W;
    localparam int SUM_W  = 64;

    // divider widths and step count, two quotient bits per clock
    localparam int DVD_W     = ACC_W - FRAC_W;
    localparam int DVS_W     = 32;
    localparam int QRAW_W    = 64;
    localparam int MAG_W     = 63;
    localparam int DIV_STEPS = QRAW_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // term magnitudes saturate at 2^62
    localparam logic [MAG_W-1:0] SAT_MAG = {1'b1, {(MAG_W-1){1'b0}}};

    // microseconds per second
    localparam logic [MUL_W-1:0] MICRO_SCALE = 32'd1000000;

    // function codes
    localparam logic [1:0] FN_COMPUTE = 2'd0;
    localparam logic [1:0] FN_ENABLE  = 2'd1;
    localparam logic [1:0] FN_DISABLE = 2'd2;
    localparam logic [1:0] FN_IGNORED = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DISABLED = 2'd1;
    localparam logic [1:0] ST_TOO_SOON = 2'd2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_TARGET     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_PROP  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_INTEG = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_DERIV = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LIMIT_LOW  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LIMIT_HIGH = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_MIN_PERIOD = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_PROP_MEAS  = 3'd7;

    typedef struct packed {
        logic signed [DATA_W-1:0] target_value;
        logic signed [DATA_W-1:0] gain_prop;
        logic signed [DATA_W-1:0] gain_integ;
        logic signed [DATA_W-1:0] gain_deriv;
        logic signed [DATA_W-1:0] limit_low;
        logic signed [DATA_W-1:0] limit_high;
        logic [DATA_W-1:0]        min_period_us;
        logic                     prop_on_meas;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        target_value:  '0,
        gain_prop:     '0,
        gain_integ:    '0,
        gain_deriv:    '0,
        limit_low:     '0,
        limit_high:    32'sh00FF0000,
        min_period_us: '0,
        prop_on_meas:  1'b0
    };

    typedef enum logic [4:0] {
        S_IDLE,
        S_DIFF,
        S_MAG,
        S_MUL_P,
        S_MUL_I,
        S_MUL_D,
        S_MUL_ILO,
        S_MUL_IHI,
        S_ACC_I,
        S_DIV_I,
        S_MUL_DHI,
        S_ACC_D,
        S_WAIT_I,
        S_WAIT_D,
        S_SUM_A,
        S_SUM_B,
        S_SUM_C,
        S_SUM_D,
        S_OUT
    } t_state;

endpackage

// ===== rtl/core/pidct_regs.sv =====
`timescale 1ns / 1ps

module pidct_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pidct_pkg::ADDR_W-1:0]  paddr,
    input  logic [pidct_pkg::DATA_W-1:0]  pwdata,
    output logic [pidct_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    output pidct_pkg::t_cfg               o_cfg
);
    import pidct_pkg::*;

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    // register writes on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_TARGET:     r_cfg.target_value  <= pwdata;
                REG_GAIN_PROP:  r_cfg.gain_prop     <= pwdata;
                REG_GAIN_INTEG: r_cfg.gain_integ    <= pwdata;
                REG_GAIN_DERIV: r_cfg.gain_deriv    <= pwdata;
                REG_LIMIT_LOW:  r_cfg.limit_low     <= pwdata;
                REG_LIMIT_HIGH: r_cfg.limit_high    <= pwdata;
                REG_MIN_PERIOD: r_cfg.min_period_us <= pwdata;
                REG_PROP_MEAS:  r_cfg.prop_on_meas  <= pwdata[0];
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (reg_idx)
            REG_TARGET:     prdata = r_cfg.target_value;
            REG_GAIN_PROP:  prdata = r_cfg.gain_prop;
            REG_GAIN_INTEG: prdata = r_cfg.gain_integ;
            REG_GAIN_DERIV: prdata = r_cfg.gain_deriv;
            REG_LIMIT_LOW:  prdata = r_cfg.limit_low;
            REG_LIMIT_HIGH: prdata = r_cfg.limit_high;
            REG_MIN_PERIOD: prdata = r_cfg.min_period_us;
            REG_PROP_MEAS:  prdata = {{(DATA_W-1){1'b0}}, r_cfg.prop_on_meas};
        endcase
    end

endmodule

// ===== rtl/core/pidct_mul.sv =====
`timescale 1ns / 1ps

module pidct_mul (
    input  logic                          i_clk,
    input  logic [pidct_pkg::MUL_W-1:0]   i_a,
    input  logic [pidct_pkg::MUL_W-1:0]   i_b,
    output logic [pidct_pkg::PROD_W-1:0]  o_prod
);
    import pidct_pkg::*;

    logic [PROD_W-1:0] r_prod;

    // unsigned 32 x 32 product, registered
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/core/pidct_div.sv =====
`timescale 1ns / 1ps

module pidct_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [pidct_pkg::DVD_W-1:0]  i_dividend,
    input  logic [pidct_pkg::DVS_W-1:0]  i_divisor,
    output logic                         o_busy,
    output logic [pidct_pkg::MAG_W-1:0]  o_quot
);
    import pidct_pkg::*;

    localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    logic                 r_busy;
    logic                 r_sat;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0]     r_dvs;
    logic [DVS_W-1:0]     r_rem;
    logic [QRAW_W-1:0]    r_quo;

    logic [DVS_W:0]       trial0, trial1, diff0, diff1;
    logic                 ge0, ge1;
    logic [DVS_W-1:0]     rem0, n_rem;
    logic [QRAW_W-1:0]    n_quo;
    logic                 hi_sat;

    // quotient would not fit in 64 bits
    assign hi_sat = DVS_W'(i_dividend[DVD_W-1:QRAW_W]) >= i_divisor;

    // two restoring steps per clock
    always_comb begin
        trial0 = {r_rem, r_quo[QRAW_W-1]};
        diff0  = trial0 - {1'b0, r_dvs};
        ge0    = trial0 >= {1'b0, r_dvs};
        rem0   = ge0 ? diff0[DVS_W-1:0] : trial0[DVS_W-1:0];
        trial1 = {rem0, r_quo[QRAW_W-2]};
        diff1  = trial1 - {1'b0, r_dvs};
        ge1    = trial1 >= {1'b0, r_dvs};
        n_rem  = ge1 ? diff1[DVS_W-1:0] : trial1[DVS_W-1:0];
        n_quo  = {r_quo[QRAW_W-3:0], ge0, ge1};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    // remainder and dividend / quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvs <= i_divisor;
            r_sat <= hi_sat;
            r_rem <= DVS_W'(i_dividend[DVD_W-1:QRAW_W]);
            r_quo <= i_dividend[QRAW_W-1:0];
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = (r_sat || (r_quo > QRAW_W'(SAT_MAG))) ? SAT_MAG : r_quo[MAG_W-1:0];

endmodule

// ===== rtl/core/pid_controller_timed_top.sv =====
`timescale 1ns / 1ps

// Timed PID controller in Q16.16: one transfer in gives one transfer out. A
// compute request runs the proportional, integral (with anti-windup clamp)
// and derivative-on-measurement terms through one registered 32x32
// multiplier and one shared divider that retires two quotient bits a clock,
// so the two divisions dominate the time a compute sample takes (by 10^6
// for the integral, by the elapsed time for the derivative). When the
// elapsed time is zero the second division is skipped. Enable, disable,
// refused and ignored requests go from the difference state straight to
// the output state. Input ready is high only between items; a finished
// result waits in the output register without holding up the next
// item. Configuration registers sit at byte address 4*index on the APB port
// and should only be written while the block is idle.
module pid_controller_timed_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [1:0]                           i_func,
    input  logic signed [pidct_pkg::DATA_W-1:0]  i_measurement,
    input  logic signed [pidct_pkg::DATA_W-1:0]  i_current_output,
    input  logic [pidct_pkg::DATA_W-1:0]         i_time_us,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [1:0]                           o_status,
    output logic signed [pidct_pkg::DATA_W-1:0]  o_drive,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pidct_pkg::ADDR_W-1:0]         paddr,
    input  logic [pidct_pkg::DATA_W-1:0]         pwdata,
    output logic [pidct_pkg::DATA_W-1:0]         prdata,
    output logic                                 pready
);
    import pidct_pkg::*;

    t_cfg   cfg;
    t_state r_state, n_state;

    // latched item
    logic [1:0]               r_func;
    logic signed [DATA_W-1:0] r_meas, r_cur;
    logic [DATA_W-1:0]        r_time;

    // controller state
    logic                     r_active;
    logic signed [DATA_W-1:0] r_integ, r_prev_meas;
    logic [DATA_W-1:0]        r_prev_time;

    // working registers
    logic signed [DIFF_W-1:0] r_err, r_din;
    logic [DATA_W-1:0]        r_dt;
    logic [MUL_W-1:0]         r_err_mag, r_din_mag, r_gp_mag, r_gi_mag, r_gd_mag;
    logic                     r_err_neg, r_din_neg, r_gp_neg, r_gi_neg, r_gd_neg;
    logic [PTM_W-1:0]         r_ptm_mag;
    logic [PROD_W-1:0]        r_pi, r_pd;
    logic [ACC_W-1:0]         r_acc;
    logic [MAG_W-1:0]         r_itm_mag, r_dtm_mag;
    logic signed [SUM_W-1:0]  r_sum;
    logic [1:0]               r_res_status;
    logic signed [DATA_W-1:0] r_res_drive;

    // output register
    logic                     r_out_valid;
    logic [1:0]               r_out_status;
    logic signed [DATA_W-1:0] r_out_drive;

    // combinational
    logic signed [DIFF_W-1:0] err_diff, din_diff;
    logic [DATA_W-1:0]        dt_diff;
    logic                     too_soon, run_pid, out_load, ptm_neg;
    logic signed [DATA_W-1:0] cur_clamped;
    logic signed [SUM_W-1:0]  sext_integ, ptm_s, itm_s, dtm_s;
    logic [MUL_W-1:0]         mul_a, mul_b;
    logic [PROD_W-1:0]        mul_prod;
    logic                     div_start, div_busy;
    logic [DVD_W-1:0]         div_dvd;
    logic [DVS_W-1:0]         div_dvs;
    logic [MAG_W-1:0]         div_quot;

    function automatic logic signed [DATA_W-1:0] clamp_q(
        input logic signed [SUM_W-1:0]  v,
        input logic signed [DATA_W-1:0] lo,
        input logic signed [DATA_W-1:0] hi
    );
        logic signed [SUM_W-1:0] lo_x, hi_x;
        lo_x = SUM_W'(lo);
        hi_x = SUM_W'(hi);
        priority if (v > hi_x) begin
            return hi;
        end else if (v < lo_x) begin
            return lo;
        end else begin
            return v[DATA_W-1:0];
        end
    endfunction

    function automatic logic [MUL_W-1:0] mag_gain(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [MUL_W-1:0] mag_diff(input logic [DIFF_W-1:0] v);
        logic [DIFF_W-1:0] n;
        n = ~v + 1'b1;
        return v[DIFF_W-1] ? n[MUL_W-1:0] : v[MUL_W-1:0];
    endfunction

    function automatic logic signed [SUM_W-1:0] to_term(
        input logic [MAG_W-1:0] m,
        input logic             neg
    );
        logic [SUM_W-1:0] v;
        v = {1'b0, m};
        return neg ? -v : v;
    endfunction

    pidct_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pidct_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    pidct_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_busy     (div_busy),
        .o_quot     (div_quot)
    );

    // differences and sample checks
    assign err_diff    = DIFF_W'(cfg.target_value) - DIFF_W'(r_meas);
    assign din_diff    = DIFF_W'(r_meas) - DIFF_W'(r_prev_meas);
    assign dt_diff     = r_time - r_prev_time;
    assign too_soon    = (cfg.min_period_us != '0) && (dt_diff <= cfg.min_period_us);
    assign run_pid     = (r_func == FN_COMPUTE) && r_active && !too_soon;
    assign cur_clamped = clamp_q(SUM_W'(r_cur), cfg.limit_low, cfg.limit_high);

    // signed terms
    assign sext_integ = SUM_W'(r_integ);
    assign ptm_neg    = r_gp_neg ^ (cfg.prop_on_meas ? r_din_neg : r_err_neg);
    assign ptm_s      = to_term(MAG_W'(r_ptm_mag), ptm_neg);
    assign itm_s      = to_term(r_itm_mag, r_gi_neg ^ r_err_neg);
    assign dtm_s      = to_term(r_dtm_mag, r_gd_neg ^ r_din_neg);

    assign div_dvd = r_acc[ACC_W-1:FRAC_W];

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer: next state, multiplier operands, divider start
    always_comb begin
        n_state   = r_state;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_dvs   = r_dt;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: n_state = run_pid ? S_MAG : S_OUT;
            S_MAG:  n_state = S_MUL_P;
            S_MUL_P: begin
                mul_a   = r_gp_mag;
                mul_b   = cfg.prop_on_meas ? r_din_mag : r_err_mag;
                n_state = S_MUL_I;
            end
            S_MUL_I: begin
                mul_a   = r_gi_mag;
                mul_b   = r_err_mag;
                n_state = S_MUL_D;
            end
            S_MUL_D: begin
                mul_a   = r_gd_mag;
                mul_b   = r_din_mag;
                n_state = S_MUL_ILO;
            end
            S_MUL_ILO: begin
                mul_a   = r_pi[MUL_W-1:0];
                mul_b   = r_dt;
                n_state = S_MUL_IHI;
            end
            S_MUL_IHI: begin
                mul_a   = r_pi[PROD_W-1:MUL_W];
                mul_b   = r_dt;
                n_state = S_ACC_I;
            end
            S_ACC_I: n_state = S_DIV_I;
            S_DIV_I: begin
                div_start = 1'b1;
                div_dvs   = MICRO_SCALE;
                mul_a     = r_pd[MUL_W-1:0];
                mul_b     = MICRO_SCALE;
                n_state   = S_MUL_DHI;
            end
            S_MUL_DHI: begin
                mul_a   = r_pd[PROD_W-1:MUL_W];
                mul_b   = MICRO_SCALE;
                n_state = S_ACC_D;
            end
            S_ACC_D: n_state = S_WAIT_I;
            S_WAIT_I: begin
                if (!div_busy) begin
                    if (r_dt != '0) begin
                        div_start = 1'b1;
                        n_state   = S_WAIT_D;
                    end else begin
                        n_state = S_SUM_A;
                    end
                end
            end
            S_WAIT_D: begin
                if (!div_busy) begin
                    n_state = S_SUM_A;
                end
            end
            S_SUM_A: n_state = S_SUM_B;
            S_SUM_B: n_state = S_SUM_C;
            S_SUM_C: n_state = S_SUM_D;
            S_SUM_D: n_state = S_OUT;
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // working datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    r_func <= i_func;
                    r_meas <= i_measurement;
                    r_cur  <= i_current_output;
                    r_time <= i_time_us;
                end
            end
            S_DIFF: begin
                r_err <= err_diff;
                r_din <= din_diff;
                r_dt  <= dt_diff;
                unique case (r_func)
                    FN_COMPUTE: begin
                        r_res_status <= !r_active ? ST_DISABLED :
                                        (too_soon ? ST_TOO_SOON : ST_OK);
                        r_res_drive  <= '0;
                    end
                    FN_ENABLE: begin
                        r_res_status <= ST_OK;
                        r_res_drive  <= r_active ? r_integ : cur_clamped;
                    end
                    FN_DISABLE: begin
                        r_res_status <= ST_DISABLED;
                        r_res_drive  <= '0;
                    end
                    FN_IGNORED: begin
                        r_res_status <= r_active ? ST_OK : ST_DISABLED;
                        r_res_drive  <= '0;
                    end
                endcase
            end
            S_MAG: begin
                r_err_mag <= mag_diff(r_err);
                r_err_neg <= r_err[DIFF_W-1];
                r_din_mag <= mag_diff(r_din);
                r_din_neg <= r_din[DIFF_W-1];
                r_gp_mag  <= mag_gain(cfg.gain_prop);
                r_gp_neg  <= cfg.gain_prop[DATA_W-1];
                r_gi_mag  <= mag_gain(cfg.gain_integ);
                r_gi_neg  <= cfg.gain_integ[DATA_W-1];
                r_gd_mag  <= mag_gain(cfg.gain_deriv);
                r_gd_neg  <= cfg.gain_deriv[DATA_W-1];
            end
            S_MUL_I:   r_ptm_mag <= mul_prod[PROD_W-1:FRAC_W];
            S_MUL_D:   r_pi      <= mul_prod;
            S_MUL_ILO: r_pd      <= mul_prod;
            S_MUL_IHI: r_acc     <= ACC_W'(mul_prod);
            S_ACC_I:   r_acc     <= r_acc + {mul_prod, {MUL_W{1'b0}}};
            S_MUL_DHI: r_acc     <= ACC_W'(mul_prod);
            S_ACC_D:   r_acc     <= r_acc + {mul_prod, {MUL_W{1'b0}}};
            S_WAIT_I: begin
                if (!div_busy) begin
                    r_itm_mag <= div_quot;
                    r_dtm_mag <= '0;
                end
            end
            S_WAIT_D: begin
                if (!div_busy) begin
                    r_dtm_mag <= div_quot;
                end
            end
            // integral sum before the clamp
            S_SUM_A: r_sum <= sext_integ + itm_s;
            S_SUM_B: begin
                if (cfg.prop_on_meas) begin
                    r_sum <= r_sum - ptm_s;
                end
            end
            // proportional less derivative
            S_SUM_C: r_sum <= (cfg.prop_on_meas ? '0 : ptm_s) - dtm_s;
            S_SUM_D: begin
                r_res_status <= ST_OK;
                r_res_drive  <= clamp_q(r_sum + sext_integ, cfg.limit_low, cfg.limit_high);
            end
            default: ;
        endcase
    end

    // controller state: enable flag, integral sum, last sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_integ     <= '0;
            r_prev_meas <= '0;
            r_prev_time <= '0;
        end else begin
            unique case (r_state)
                S_DIFF: begin
                    if (r_func == FN_ENABLE && !r_active) begin
                        r_active    <= 1'b1;
                        r_prev_time <= r_time;
                        r_prev_meas <= r_meas;
                        r_integ     <= cur_clamped;
                    end else if (r_func == FN_DISABLE) begin
                        r_active <= 1'b0;
                    end
                end
                S_SUM_C: r_integ <= clamp_q(r_sum, cfg.limit_low, cfg.limit_high);
                S_SUM_D: begin
                    r_prev_meas <= r_meas;
                    r_prev_time <= r_time;
                end
                default: ;
            endcase
        end
    end

    // output register, loads when empty or being drained
    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_drive  <= r_res_drive;
        end
    end

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;
    assign o_drive  = r_out_drive;

endmodule

// ===== bench/pid_controller_timed_top_tb.sv =====
`timescale 1ns / 1ps

module pid_controller_timed_top_tb;
    import pidct_pkg::*;

    localparam int LONG_HOLD  = 400;
    localparam int DRAIN_WAIT = 100;
    localparam int PRINT_CAP  = 40;
    localparam int RUN_PHASES = 9;

    // scale factors of the integral and proportional terms, and the term cap
    localparam logic [47:0] INTEG_SCALE = 48'd65536000000;
    localparam logic [47:0] Q16_ONE     = 48'd65536;
    localparam logic [62:0] TERM_CAP    = {1'b1, 62'd0};

    typedef struct packed {
        logic [1:0]               func;
        logic signed [DATA_W-1:0] measurement;
        logic signed [DATA_W-1:0] current_output;
        logic [DATA_W-1:0]        time_us;
    } pid_sample_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] drive;
    } pid_answer_t;

    logic                     i_clk            = 1'b0;
    logic                     i_rst_n          = 1'b0;
    logic                     i_valid          = 1'b0;
    logic                     o_ready;
    logic [1:0]               i_func           = FN_COMPUTE;
    logic signed [DATA_W-1:0] i_measurement    = '0;
    logic signed [DATA_W-1:0] i_current_output = '0;
    logic [DATA_W-1:0]        i_time_us        = '0;
    logic                     o_valid;
    logic                     i_ready          = 1'b0;
    logic [1:0]               o_status;
    logic signed [DATA_W-1:0] o_drive;
    logic                     psel             = 1'b0;
    logic                     penable          = 1'b0;
    logic                     pwrite           = 1'b0;
    logic [ADDR_W-1:0]        paddr            = '0;
    logic [DATA_W-1:0]        pwdata           = '0;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;

    pid_controller_timed_top uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_func           (i_func),
        .i_measurement    (i_measurement),
        .i_current_output (i_current_output),
        .i_time_us        (i_time_us),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_drive          (o_drive),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // controller model: register copy and loop state
    t_cfg                     pid_cfg    = CFG_RESET;
    logic                     pid_active = 1'b0;
    logic signed [DATA_W-1:0] integ_sum  = '0;
    logic signed [DATA_W-1:0] last_meas  = '0;
    logic [DATA_W-1:0]        last_time  = '0;

    pid_sample_t sample_q[$];
    pid_answer_t answer_q[$];

    int   mismatch_cnt    = 0;
    int   accepted_cnt    = 0;
    int   checked_cnt     = 0;
    int   ok_cnt          = 0;
    int   disabled_cnt    = 0;
    int   too_soon_cnt    = 0;
    int   tx_gap          = 0;
    int   rx_gap          = 0;
    int   long_stall_left = 0;
    logic in_fire         = 1'b0;
    logic quiet_run       = 1'b0;
    logic long_stall_req  = 1'b0;
    logic long_stall_done = 1'b0;
    logic [DATA_W-1:0] stim_now = '0;

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(20_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        mismatch_cnt++;
        if (mismatch_cnt <= PRINT_CAP) begin
            $display("[%0t] %s", $time, what);
        end
    endtask

    // signed a*b*k/d truncated toward zero, magnitude capped at 2^62
    function automatic logic signed [63:0] scaled_term(input logic signed [63:0] a,
                                                       input logic signed [63:0] b,
                                                       input logic [31:0] k,
                                                       input logic [47:0] d);
        logic [63:0]  mag_a;
        logic [63:0]  mag_b;
        logic [127:0] wide;
        mag_a = a[63] ? -a : a;
        mag_b = b[63] ? -b : b;
        wide = 128'(mag_a) * 128'(mag_b) * 128'(k) / 128'(d);
        if (wide > 128'(TERM_CAP)) begin
            wide = 128'(TERM_CAP);
        end
        if (a[63] != b[63]) begin
            return -$signed(wide[63:0]);
        end
        return $signed(wide[63:0]);
    endfunction

    // upper limit is tested first, so it wins when the limits are inverted
    function automatic logic signed [DATA_W-1:0] clamp_limits(input logic signed [63:0] v);
        logic signed [63:0] lo;
        logic signed [63:0] hi;
        lo = $signed(pid_cfg.limit_low);
        hi = $signed(pid_cfg.limit_high);
        if (v > hi) begin
            return hi[DATA_W-1:0];
        end
        if (v < lo) begin
            return lo[DATA_W-1:0];
        end
        return v[DATA_W-1:0];
    endfunction

    // one controller step, updates the model state
    function automatic pid_answer_t pid_step(input pid_sample_t s);
        pid_answer_t        ans;
        logic [31:0]        dt;
        logic signed [63:0] err;
        logic signed [63:0] din;
        logic signed [63:0] acc;
        logic signed [63:0] prop;
        logic signed [63:0] deriv;
        ans.status = ST_OK;
        ans.drive  = '0;
        dt = s.time_us - last_time;
        case (s.func)
            FN_COMPUTE: begin
                if (!pid_active) begin
                    ans.status = ST_DISABLED;
                end else if (pid_cfg.min_period_us != 0 && dt <= pid_cfg.min_period_us) begin
                    ans.status = ST_TOO_SOON;
                end else begin
                    err  = $signed(pid_cfg.target_value) - $signed(s.measurement);
                    din  = $signed(s.measurement) - last_meas;
                    prop = '0;
                    acc  = integ_sum + scaled_term($signed(pid_cfg.gain_integ), err, dt,
                                                   INTEG_SCALE);
                    if (pid_cfg.prop_on_meas) begin
                        acc = acc - scaled_term($signed(pid_cfg.gain_prop), din, 32'd1, Q16_ONE);
                    end else begin
                        prop = scaled_term($signed(pid_cfg.gain_prop), err, 32'd1, Q16_ONE);
                    end
                    integ_sum = clamp_limits(acc);
                    if (dt != 0) begin
                        deriv = scaled_term($signed(pid_cfg.gain_deriv), din, MICRO_SCALE,
                                            {dt, 16'd0});
                    end else begin
                        deriv = '0;
                    end
                    ans.drive = clamp_limits(prop + integ_sum - deriv);
                    last_meas = s.measurement;
                    last_time = s.time_us;
                end
            end
            FN_ENABLE: begin
                if (!pid_active) begin
                    pid_active = 1'b1;
                    last_time  = s.time_us;
                    last_meas  = s.measurement;
                    integ_sum  = clamp_limits($signed(s.current_output));
                end
                ans.drive = integ_sum;
            end
            FN_DISABLE: begin
                pid_active = 1'b0;
                ans.status = ST_DISABLED;
            end
            default: begin
                ans.status = pid_active ? ST_OK : ST_DISABLED;
            end
        endcase
        return ans;
    endfunction

    // sample driver, changes at the falling edge
    always @(negedge i_clk) begin : sample_driver
        pid_sample_t nxt;
        if (i_rst_n && (!i_valid || in_fire)) begin
            if (tx_gap != 0) begin
                tx_gap  <= tx_gap - 1;
                i_valid <= 1'b0;
            end else if (!quiet_run && $urandom_range(0, 5) == 0) begin
                tx_gap  <= $urandom_range(0, 2);
                i_valid <= 1'b0;
            end else if (sample_q.size() != 0) begin
                nxt = sample_q.pop_front();
                i_func           <= nxt.func;
                i_measurement    <= nxt.measurement;
                i_current_output <= nxt.current_output;
                i_time_us        <= nxt.time_us;
                i_valid          <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result receiver: short random stalls plus one long hold-off
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (long_stall_left != 0) begin
                long_stall_left <= long_stall_left - 1;
                i_ready         <= 1'b0;
            end else if (long_stall_req && !long_stall_done) begin
                long_stall_done <= 1'b1;
                long_stall_left <= LONG_HOLD;
                i_ready         <= 1'b0;
            end else if (rx_gap != 0) begin
                rx_gap  <= rx_gap - 1;
                i_ready <= 1'b0;
            end else if (!quiet_run && $urandom_range(0, 5) == 0) begin
                rx_gap  <= $urandom_range(0, 2);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // result check and prediction, sampled at the rising edge
    always @(posedge i_clk) begin : result_check
        pid_answer_t want;
        pid_sample_t got_in;
        in_fire <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && o_valid && i_ready) begin
            if (answer_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected result transfer: status %0d drive %h",
                                        o_status, o_drive));
            end else begin
                want = answer_q.pop_front();
                checked_cnt++;
                if (o_status !== want.status) begin
                    flag_mismatch($sformatf("status %0d, expected %0d", o_status, want.status));
                end
                if (o_drive !== want.drive) begin
                    flag_mismatch($sformatf("drive %h, expected %h", o_drive, want.drive));
                end
            end
        end
        if (i_rst_n && i_valid && o_ready) begin
            got_in = '{i_func, i_measurement, i_current_output, i_time_us};
            want   = pid_step(got_in);
            answer_q.push_back(want);
            accepted_cnt++;
            case (want.status)
                ST_OK:       ok_cnt++;
                ST_DISABLED: disabled_cnt++;
                default:     too_soon_cnt++;
            endcase
        end
    end

    // apb write then read back
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] keep;
        keep = (idx == REG_PROP_MEAS) ? 32'h1 : 32'hFFFF_FFFF;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            REG_TARGET:     pid_cfg.target_value  = value;
            REG_GAIN_PROP:  pid_cfg.gain_prop     = value;
            REG_GAIN_INTEG: pid_cfg.gain_integ    = value;
            REG_GAIN_DERIV: pid_cfg.gain_deriv    = value;
            REG_LIMIT_LOW:  pid_cfg.limit_low     = value;
            REG_LIMIT_HIGH: pid_cfg.limit_high    = value;
            REG_MIN_PERIOD: pid_cfg.min_period_us = value;
            default:        pid_cfg.prop_on_meas  = value[0];
        endcase
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if ((prdata & keep) !== (value & keep)) begin
            flag_mismatch($sformatf("register %0d reads %h, written %h", idx, prdata, value));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_settings(input logic [31:0] tgt, input logic [31:0] kp,
                                 input logic [31:0] ki, input logic [31:0] kd,
                                 input logic [31:0] lo, input logic [31:0] hi,
                                 input logic [31:0] minp, input logic pom);
        write_reg(REG_TARGET, tgt);
        write_reg(REG_GAIN_PROP, kp);
        write_reg(REG_GAIN_INTEG, ki);
        write_reg(REG_GAIN_DERIV, kd);
        write_reg(REG_LIMIT_LOW, lo);
        write_reg(REG_LIMIT_HIGH, hi);
        write_reg(REG_MIN_PERIOD, minp);
        write_reg(REG_PROP_MEAS, {31'd0, pom});
    endtask

    task automatic push_sample(input logic [1:0] func, input logic [31:0] meas,
                               input logic [31:0] cur, input logic [31:0] t_us);
        sample_q.push_back('{func, meas, cur, t_us});
    endtask

    // wait until every transfer is in and every result is out
    task automatic wait_drained();
        while (sample_q.size() != 0 || i_valid || answer_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_gain();
        return $signed($urandom) >>> $urandom_range(2, 20);
    endfunction

    // measurement mostly near the setpoint, sometimes anywhere
    function automatic logic [31:0] near_target();
        if ($urandom_range(0, 19) == 0) begin
            return $urandom;
        end
        return $signed(pid_cfg.target_value) + ($signed($urandom) >>> $urandom_range(6, 31));
    endfunction

    function automatic logic [31:0] rand_drive();
        if ($urandom_range(0, 1) == 0) begin
            return $urandom;
        end
        return $signed($urandom) >>> $urandom_range(8, 31);
    endfunction

    // elapsed time: mostly short, with zero, boundary and wild steps
    function automatic logic [31:0] pick_step();
        int pick;
        pick = $urandom_range(0, 19);
        case (pick)
            0:       return '0;
            1:       return pid_cfg.min_period_us;
            2:       return pid_cfg.min_period_us + 1;
            3:       return $urandom;
            default: return $urandom_range(1, 4000);
        endcase
    endfunction

    // enable, then a control run with random content and some noise
    task automatic queue_control_run(input int count);
        int n;
        int pick;
        stim_now += pick_step();
        push_sample(FN_ENABLE, near_target(), rand_drive(), stim_now);
        for (n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            stim_now += pick_step();
            if (pick < 78) begin
                push_sample(FN_COMPUTE, near_target(), $urandom, stim_now);
            end else if (pick < 85) begin
                push_sample(FN_ENABLE, near_target(), rand_drive(), stim_now);
            end else if (pick < 90) begin
                push_sample(FN_DISABLE, $urandom, $urandom, stim_now);
                if ($urandom_range(0, 2) != 0) begin
                    push_sample(FN_ENABLE, near_target(), rand_drive(), stim_now + 1);
                end
            end else if (pick < 94) begin
                push_sample(FN_IGNORED, $urandom, $urandom, $urandom);
            end else begin
                push_sample(FN_COMPUTE, $urandom, $urandom, $urandom);
            end
        end
    endtask

    task automatic load_random_settings();
        logic [31:0] a;
        logic [31:0] b;
        a = $urandom;
        b = $urandom;
        if ($signed(a) > $signed(b)) begin
            {a, b} = {b, a};
        end
        load_settings($signed($urandom) >>> $urandom_range(0, 12), rand_gain(), rand_gain(),
                      rand_gain(), a, b,
                      ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom_range(1, 1500),
                      $urandom_range(0, 1));
    endtask

    // main sequence
    initial begin : main_seq
        int ph;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // directed: modest gains, +-100 limits, 100 us minimum period
        load_settings(32'h0005_0000, 32'h0002_0000, 32'h0040_0000, 32'h0000_4000,
                      32'hFF9C_0000, 32'h0064_0000, 32'd100, 1'b0);
        push_sample(FN_COMPUTE, 32'h0000_0000, 32'h0000_0000, 32'd1000);
        push_sample(FN_IGNORED, 32'h0000_0000, 32'h0000_0000, 32'd1000);
        push_sample(FN_DISABLE, 32'h0000_0000, 32'h0000_0000, 32'd1000);
        // enable with the seed above the upper limit
        push_sample(FN_ENABLE, 32'h0005_0000, 32'h7FFF_FFFF, 32'd1000);
        // enable while active changes nothing
        push_sample(FN_ENABLE, 32'h0001_0000, 32'h8000_0000, 32'd5000);
        push_sample(FN_IGNORED, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        // minimum period boundary: equal is too soon, one more is fine
        push_sample(FN_COMPUTE, 32'h0004_0000, 32'h0000_0000, 32'd1100);
        push_sample(FN_COMPUTE, 32'h0004_0000, 32'h0000_0000, 32'd1101);
        push_sample(FN_COMPUTE, 32'h7FFF_FFFF, 32'h0000_0000, 32'd2101);
        push_sample(FN_COMPUTE, 32'h8000_0000, 32'h0000_0000, 32'd3102);
        // timestamp wrapping through zero
        push_sample(FN_COMPUTE, 32'h0005_0000, 32'h0000_0000, 32'hFFFF_FF00);
        push_sample(FN_COMPUTE, 32'h0006_0000, 32'h0000_0000, 32'h0000_0100);
        push_sample(FN_DISABLE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0200);
        push_sample(FN_COMPUTE, 32'h0000_0000, 32'h0000_0000, 32'h0000_1000);
        // enable with the seed below the lower limit
        push_sample(FN_ENABLE, 32'h0000_0000, 32'h8000_0000, 32'h0000_2000);
        push_sample(FN_COMPUTE, 32'h0005_0000, 32'h0000_0000, 32'h0000_2100);
        wait_drained();

        // zero elapsed time with proportional on measurement
        write_reg(REG_MIN_PERIOD, 32'd0);
        write_reg(REG_PROP_MEAS, 32'd1);
        push_sample(FN_COMPUTE, 32'h0005_0000, 32'h0000_0000, 32'h0000_2100);
        push_sample(FN_COMPUTE, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_2101);
        push_sample(FN_COMPUTE, 32'h8000_0000, 32'h0000_0000, 32'h0000_2101);
        push_sample(FN_COMPUTE, 32'h0005_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_drained();
        stim_now = 32'hFFFF_FFFF;

        // random control runs, one register setting per phase
        for (ph = 0; ph < RUN_PHASES; ph++) begin
            case (ph)
                0: load_settings(32'h0003_0000, 32'h0002_8000, 32'h0020_0000, 32'h0000_0800,
                                 32'hFF38_0000, 32'h00C8_0000, 32'd0, 1'b0);
                1: load_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 1'b1);
                2: load_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                 32'h8000_0000, 32'h7FFF_FFFF, 32'd500, 1'b0);
                // inverted limits
                3: load_settings(32'h0001_0000, rand_gain(), rand_gain(), rand_gain(),
                                 32'h0010_0000, 32'hFFF0_0000, 32'd0, 1'b1);
                // every compute while enabled refused as too soon
                4: load_settings(32'h0001_0000, rand_gain(), rand_gain(), rand_gain(),
                                 32'hFF00_0000, 32'h0100_0000, 32'hFFFF_FFFF, 1'b0);
                default: load_random_settings();
            endcase
            if (ph == 0) begin
                long_stall_req = 1'b1;
            end
            if (ph == RUN_PHASES - 1) begin
                quiet_run = 1'b1;
            end
            queue_control_run((ph == 4) ? 30 : 115);
            wait_drained();
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("run covered %0d sample transfers and %0d checked results over %0d settings",
                 accepted_cnt, checked_cnt, RUN_PHASES + 2);
        $display("results: %0d ok, %0d disabled, %0d too soon, %0d mismatches",
                 ok_cnt, disabled_cnt, too_soon_cnt, mismatch_cnt);
        if (mismatch_cnt == 0 && answer_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== pid_controller_timed_top.f =====
rtl/core/pidct_pkg.sv
rtl/core/pidct_regs.sv
rtl/core/pidct_mul.sv
rtl/core/pidct_div.sv
rtl/core/pid_controller_timed_top.sv
bench/pid_controller_timed_top_tb.sv
